>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ui2d_pkg.sv
// Shared types and constants for the 64-bit binary to decimal text converter.
package ui2d_pkg;

   localparam int VALUE_W    = 64;
   localparam int NUM_DIGITS = 20;
   localparam int BCD_W      = 4 * NUM_DIGITS;
   localparam int CHAR_W     = 6;
   localparam int CNT_W      = 6;

   localparam logic [CNT_W-1:0]  CONV_LAST  = CNT_W'(VALUE_W - 1);
   localparam logic [CNT_W-1:0]  EMIT_LAST  = CNT_W'(NUM_DIGITS - 1);
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
   localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } ui2d_state_type;

   // Control from the sequencer to the digit datapath.
   typedef struct packed {
      logic load;   // capture a new value, clear the digits
      logic conv;   // one shift-add-3 step
      logic emit;   // shift out the top digit
   } ui2d_ctrl_type;

   // Double-dabble correction on one BCD digit.
   function automatic logic [3:0] dabble_adj(input logic [3:0] nib);
      dabble_adj = (nib >= 4'd5) ? (nib + 4'd3) : nib;
   endfunction

endpackage

>>> rtl/core/ui2d_dabble.sv
// Bit-serial binary to BCD datapath with digit shift-out.
module ui2d_dabble (
   input  logic                         clock,
   input  ui2d_pkg::ui2d_ctrl_type      ctrl,
   input  logic [ui2d_pkg::VALUE_W-1:0] value,
   output logic [3:0]                   top_digit
);
   import ui2d_pkg::*;

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [BCD_W-1:0]   bcd_adj;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = dabble_adj(bcd_ff[4*i +: 4]);
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         bin_in = value;
         bcd_in = '0;
      end else if (ctrl.conv) begin
         bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
      end else if (ctrl.emit) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
      end
   end

   // Payload only, no reset.
   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule

>>> rtl/core/uint64_to_decimal_ascii_top.sv
// Top level: unsigned 64-bit value to decimal ASCII digits, most significant first.
//
//   channel   ports                               transfer condition
//   -------   ---------------------------------   -------------------------------
//   request   start, busy, req_value[63:0]        start high while busy low
//   response  rsp_strobe, rsp_digit_char[5:0],    rsp_strobe high, one cycle each,
//             rsp_last                            never held off
//
// Each transaction runs shift-add-3 on the value, one input bit per cycle through
// the BCD shift register, then 20 digit slots, one BCD digit shifted out per
// cycle; a new request is accepted only after the last slot.
// Leading-zero slots produce no strobe, so the digits of a value come in a
// contiguous burst ending on the final slot, which carries rsp_last.
// Synchronous active-high reset returns the sequencer to idle; the datapath
// registers are not reset. The receiver cannot stall, so there is no backpressure.
module uint64_to_decimal_ascii_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ui2d_pkg::VALUE_W-1:0] req_value,
   output logic                         rsp_strobe,
   output logic [ui2d_pkg::CHAR_W-1:0]  rsp_digit_char,
   output logic                         rsp_last
);
   import ui2d_pkg::*;

   ui2d_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             started_ff, started_in;   // first nonzero digit already sent
   ui2d_ctrl_type    ctrl;
   logic [3:0]       top_digit;
   logic             accept;
   logic             final_slot;

   assign accept     = start && (state_ff == ST_IDLE);
   assign final_slot = (cnt_ff == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (final_slot) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (final_slot) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath controls and handshake outputs.
   always_comb begin
      ctrl       = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      rsp_last   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy      = 1'b0;
            ctrl.load = start;
         end
         ST_CONV: begin
            ctrl.conv = 1'b1;
         end
         ST_EMIT: begin
            ctrl.emit = 1'b1;
            // Suppress leading zeros; the last slot always goes out (value zero).
            rsp_strobe = started_ff || (top_digit != 4'd0) || final_slot;
            rsp_last   = final_slot;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   assign rsp_digit_char = ASCII_ZERO + {2'b00, top_digit};

   // Slot counter: conversion bits, then digit positions.
   always_comb begin
      cnt_in     = cnt_ff;
      started_in = started_ff;
      if (accept) begin
         cnt_in     = CONV_LAST;
         started_in = 1'b0;
      end else if (state_ff == ST_CONV) begin
         cnt_in = final_slot ? EMIT_LAST : (cnt_ff - 1'b1);
      end else if (state_ff == ST_EMIT) begin
         cnt_in     = cnt_ff - 1'b1;
         started_in = started_ff || (top_digit != 4'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         started_ff <= started_in;
      end
   end

   ui2d_dabble u_dabble (
      .clock     (clock),
      .ctrl      (ctrl),
      .value     (req_value),
      .top_digit (top_digit)
   );

endmodule

>>> rtl/core/ui2d_checker.sv
// Port-level checker for the converter top level, with its bind.
`include "assert_macros.svh"

module ui2d_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_strobe,
   input logic [ui2d_pkg::CHAR_W-1:0] rsp_digit_char,
   input logic                        rsp_last
);
   import ui2d_pkg::*;

   `CHK_IMPLIES(a_strobe_busy, clock, reset, rsp_strobe, busy, "digit outside a transaction")
   `CHK_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept did not raise busy")
   `CHK_IMPLIES(a_digit_range, clock, reset, rsp_strobe, (rsp_digit_char >= ASCII_ZERO) && (rsp_digit_char <= ASCII_NINE), "digit code out of range")
   `CHK_NEXT(a_last_ends, clock, reset, rsp_strobe && rsp_last, !rsp_strobe && !busy, "output after last digit")
   `CHK_IMPLIES(a_done_last, clock, reset, $fell(busy) && !$past(reset), $past(rsp_strobe && rsp_last), "transaction ended without last digit")

endmodule

bind uint64_to_decimal_ascii_top ui2d_checker u_ui2d_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_digit_char (rsp_digit_char),
   .rsp_last       (rsp_last)
);

>>> verif/tb_top.sv
// Self-checking testbench for the 64-bit binary to decimal ASCII digit converter.
module tb_top;
   import ui2d_pkg::*;

   // Run control
   localparam int NUM_RANDOM   = 440;
   localparam int RESET_CYCLES = 6;
   localparam int MAX_GAP      = 16;
   // After the last digit, keep watching for stray strobes.
   localparam int DRAIN_CYCLES = 200;
   // The slowest legal run is ~460 transactions with their idle gaps and drain
   // waits; take the limit many times over.
   localparam int CYCLE_LIMIT  = 500000;
   // Stretch length (in transactions); one stretch in three runs back to back.
   localparam int BURST_LEN    = 40;

   localparam logic [VALUE_W-1:0] RADIX = VALUE_W'(10);

   // One queued request; drain_first holds it until every digit owed has come.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               drain_first;
   } pending_item_type;

   // One expected digit strobe.
   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } digit_type;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                busy;
   logic                rsp_strobe;
   logic [CHAR_W-1:0]   rsp_digit_char;
   logic                rsp_last;

   pending_item_type pending_items[$];
   digit_type        expected_digits[$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int accepted_count = 0;
   int gap_left       = 0;

   uint64_to_decimal_ascii_top DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Synchronous reset, asserted once at the start.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("[cycle %0d] MISMATCH %s: got %0d, want %0d", cycle_count, what, got, want);
   endtask

   // Decimal expansion of one value: digits are peeled off least significant
   // first, then queued most significant first. Zero still yields one digit;
   // 2^64-1 gives the full twenty.
   task automatic predict_digits(input logic [VALUE_W-1:0] value);
      logic [3:0]         digs [NUM_DIGITS];
      logic [VALUE_W-1:0] rest;
      int                 count;
      digit_type          d;
      rest  = value;
      count = 0;
      do begin
         digs[count] = 4'(rest % RADIX);
         rest        = rest / RADIX;
         count++;
      end while (rest != '0 && count < NUM_DIGITS);
      for (int k = 0; k < count; k++) begin
         d.digit_char = ASCII_ZERO + CHAR_W'(digs[count - 1 - k]);
         d.last       = (k == count - 1);
         expected_digits.push_back(d);
      end
   endtask

   // Driver: a transaction is taken at an edge with start high and busy low.
   // start stays high through busy, so requests raised mid-conversion are
   // exercised. The idle gap only counts down on cycles where busy is low,
   // so the drawn gap is real dead time in front of the next accept.
   always @(posedge clock) begin : driver
      logic accepted;
      logic burst;
      accepted = !reset && start && !busy;
      if (accepted) begin
         predict_digits(req_value);
         void'(pending_items.pop_front());
         accepted_count++;
         // every third stretch runs back to back with no idling
         burst    = ((accepted_count / BURST_LEN) % 3) == 1;
         gap_left = burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (reset) begin
         start <= 1'b0;
      end else if (start && !accepted) begin
         // hold the request until busy drops
      end else if (gap_left > 0) begin
         start <= 1'b0;
         if (!busy) gap_left--;
      end else if (pending_items.size() != 0 &&
                   !(pending_items[0].drain_first && expected_digits.size() != 0)) begin
         start     <= 1'b1;
         req_value <= pending_items[0].value;
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: each strobe is one digit; it must match the oldest expectation.
   always @(posedge clock) begin : monitor
      digit_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (expected_digits.size() == 0) begin
            report_mismatch("digit with nothing expected, char", int'(rsp_digit_char), -1);
         end else begin
            want = expected_digits.pop_front();
            if (rsp_digit_char !== want.digit_char)
               report_mismatch("digit_char", int'(rsp_digit_char), int'(want.digit_char));
            if (rsp_last !== want.last)
               report_mismatch("last", int'(rsp_last), int'(want.last));
         end
      end
   end

   // Stimulus and end of run.
   initial begin : stimulus
      logic [VALUE_W-1:0] v;
      logic [VALUE_W-1:0] pow10;
      int                 mode;
      int                 k;

      // Directed: zero, single digits, digit-count boundaries, bit patterns,
      // and the largest value with its twenty digits.
      pending_items.push_back('{value: 64'd0,                    drain_first: 1'b0});
      pending_items.push_back('{value: 64'd1,                    drain_first: 1'b0});
      pending_items.push_back('{value: 64'd9,                    drain_first: 1'b0});
      pending_items.push_back('{value: 64'd10,                   drain_first: 1'b0});
      pending_items.push_back('{value: 64'd99,                   drain_first: 1'b0});
      pending_items.push_back('{value: 64'd100,                  drain_first: 1'b0});
      pending_items.push_back('{value: 64'd4294967295,           drain_first: 1'b0});
      pending_items.push_back('{value: 64'd4294967296,           drain_first: 1'b0});
      pending_items.push_back('{value: 64'd1000000000000000000,  drain_first: 1'b0});
      pending_items.push_back('{value: 64'd9999999999999999999,  drain_first: 1'b0});
      pending_items.push_back('{value: 64'd10000000000000000000, drain_first: 1'b0});
      pending_items.push_back('{value: 64'd12345678901234567890, drain_first: 1'b0});
      pending_items.push_back('{value: 64'h7FFF_FFFF_FFFF_FFFF,  drain_first: 1'b0});
      pending_items.push_back('{value: 64'h8000_0000_0000_0000,  drain_first: 1'b0});
      pending_items.push_back('{value: 64'hAAAA_AAAA_AAAA_AAAA,  drain_first: 1'b0});
      pending_items.push_back('{value: 64'h5555_5555_5555_5555,  drain_first: 1'b0});
      pending_items.push_back('{value: 64'hFFFF_FFFF_FFFF_FFFE,  drain_first: 1'b0});
      pending_items.push_back('{value: 64'hFFFF_FFFF_FFFF_FFFF,  drain_first: 1'b0});
      // zero again, but only once the converter has fully drained
      pending_items.push_back('{value: 64'd0,                    drain_first: 1'b1});
      pending_items.push_back('{value: 64'd1010101010101010101,  drain_first: 1'b0});

      // Random: mixed magnitudes so every digit count shows up.
      for (int i = 0; i < NUM_RANDOM; i++) begin
         mode = $urandom_range(0, 9);
         if (mode <= 3) begin
            v = {$urandom, $urandom};
         end else if (mode <= 6) begin
            v = {$urandom, $urandom} >> $urandom_range(0, VALUE_W - 1);
         end else if (mode == 7) begin
            // near a power of ten, where the digit count changes
            k     = $urandom_range(0, NUM_DIGITS - 1);
            pow10 = 64'd1;
            repeat (k) pow10 = pow10 * RADIX;
            v = pow10 + VALUE_W'($urandom_range(0, 2)) - 64'd1;
         end else if (mode == 8) begin
            v = VALUE_W'($urandom_range(0, 999));
         end else begin
            // twenty-digit values
            v = 64'd10000000000000000000 + ({$urandom, $urandom} % 64'd8446744073709551616);
         end
         pending_items.push_back('{value: v, drain_first: ($urandom_range(0, 39) == 0)});
      end

      while (!(pending_items.size() == 0 && !start && expected_digits.size() == 0) &&
             cycle_count < CYCLE_LIMIT)
         @(posedge clock);

      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d digits still owed",
                  cycle_count, expected_digits.size());
         $display("end of test: mismatches");
      end else begin
         // catch stray strobes after the last expected digit
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (mismatch_count == 0 && expected_digits.size() == 0) begin
            $display("end of test: clean");
         end else begin
            $display("end of test: mismatches");
         end
      end
      $finish;
   end

endmodule
